### design/pesf_pkg.sv
`default_nettype none

package pesf_pkg;

    localparam int unsigned OP_W     = 4;
    localparam int unsigned REJ_W    = 4;
    localparam int unsigned STATE_W  = 3;
    localparam int unsigned PERM_W   = 5;
    localparam int unsigned ID_W     = 64;
    localparam int unsigned FLAGS_W  = 8;
    localparam int unsigned ERR_W    = 8;

    // item opcodes
    localparam logic [OP_W-1:0] OP_READINESS = 4'd0;
    localparam logic [OP_W-1:0] OP_PLAN      = 4'd1;
    localparam logic [OP_W-1:0] OP_EXECUTE   = 4'd2;
    localparam logic [OP_W-1:0] OP_PAUSE     = 4'd3;
    localparam logic [OP_W-1:0] OP_RESUME    = 4'd4;
    localparam logic [OP_W-1:0] OP_ABORT     = 4'd5;
    localparam logic [OP_W-1:0] OP_VALIDATED = 4'd6;
    localparam logic [OP_W-1:0] OP_PLAN_FAIL = 4'd7;
    localparam logic [OP_W-1:0] OP_PAUSE_OK  = 4'd8;
    localparam logic [OP_W-1:0] OP_SUCCESS   = 4'd9;
    localparam logic [OP_W-1:0] OP_FAULT     = 4'd10;

    // reject codes
    localparam logic [REJ_W-1:0] REJ_NONE          = 4'd0;
    localparam logic [REJ_W-1:0] REJ_PLAN_DENIED   = 4'd1;
    localparam logic [REJ_W-1:0] REJ_NOT_READY     = 4'd2;
    localparam logic [REJ_W-1:0] REJ_EXEC_DENIED   = 4'd3;
    localparam logic [REJ_W-1:0] REJ_STALE         = 4'd4;
    localparam logic [REJ_W-1:0] REJ_PAUSE_DENIED  = 4'd5;
    localparam logic [REJ_W-1:0] REJ_RESUME_DENIED = 4'd6;
    localparam logic [REJ_W-1:0] REJ_TOLERANCE     = 4'd7;
    localparam logic [REJ_W-1:0] REJ_ABORT_DENIED  = 4'd8;

    // permission bit positions
    localparam int unsigned P_PLAN   = 0;
    localparam int unsigned P_EXEC   = 1;
    localparam int unsigned P_PAUSE  = 2;
    localparam int unsigned P_RESUME = 3;
    localparam int unsigned P_ABORT  = 4;

    localparam logic [ERR_W-1:0]   ERR_NONE           = 8'd0;
    localparam logic [ERR_W-1:0]   ERR_READINESS_LOST = 8'd1;
    localparam logic [FLAGS_W-1:0] FLAGS_ALL_OK       = 8'hFF;

    // permission set per state, indexed by state number
    function automatic logic [PERM_W-1:0] perm_of(input logic [STATE_W-1:0] st);
        logic [PERM_W-1:0] p;
        case (st)
            3'd0:    p = 5'b00000;
            3'd1:    p = 5'b00001;
            3'd2:    p = 5'b10000;
            3'd3:    p = 5'b10011;
            3'd4:    p = 5'b10100;
            3'd5:    p = 5'b11000;
            3'd6:    p = 5'b00001;
            3'd7:    p = 5'b10000;
            default: p = 5'b00000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### design/plan_execute_supervisor_fsm_core.sv
`default_nettype none

// Plan/execute supervisor. One item (readiness update, command or event) is
// taken per beat on the input channel and gives exactly one result beat.
// Sustained rate is one item per cycle while the result side is not stalled;
// an accepted item is held in the input register while the state update and
// result are computed in a single pass into the result register.
// The supervisor state is updated in the same cycle the result is written,
// so back-to-back items see each other's effects. Input ready drops only
// while the result register is full and not being taken.
module plan_execute_supervisor_fsm_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [pesf_pkg::OP_W-1:0]      op,
    input  wire logic [pesf_pkg::FLAGS_W-1:0]   ready_flags,
    input  wire logic [pesf_pkg::ID_W-1:0]      cand_id,
    input  wire logic [pesf_pkg::ID_W-1:0]      session_tag,
    input  wire logic [pesf_pkg::ERR_W-1:0]     fault_code,
    input  wire logic                           tol_ok,
    input  wire logic                           candidate_valid,
    input  wire logic                           protocol_corrupt,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                accepted,
    output logic [pesf_pkg::REJ_W-1:0]          reject_code,
    output logic [pesf_pkg::STATE_W-1:0]        cur_state,
    output logic [pesf_pkg::PERM_W-1:0]         allowed_cmds,
    output logic [pesf_pkg::ID_W-1:0]           planned_id,
    output logic [pesf_pkg::ID_W-1:0]           session_num,
    output logic [pesf_pkg::ERR_W-1:0]          error_code_out,
    output logic                                is_ready
);

    typedef enum logic [pesf_pkg::STATE_W-1:0] {
        ST_NOTREADY  = 3'd0,
        ST_READY     = 3'd1,
        ST_PLANNING  = 3'd2,
        ST_PLANNED   = 3'd3,
        ST_EXECUTING = 3'd4,
        ST_PAUSED    = 3'd5,
        ST_SUCCEEDED = 3'd6,
        ST_ERROR     = 3'd7
    } state_t;

    // input register
    logic                           ir_valid_reg;
    logic [pesf_pkg::OP_W-1:0]      ir_op_reg;
    logic [pesf_pkg::FLAGS_W-1:0]   ir_flags_reg;
    logic [pesf_pkg::ID_W-1:0]      ir_cand_reg;
    logic [pesf_pkg::ID_W-1:0]      ir_tag_reg;
    logic [pesf_pkg::ERR_W-1:0]     ir_code_reg;
    logic                           ir_tol_reg;
    logic                           ir_cvalid_reg;
    logic                           ir_corrupt_reg;

    // supervisor state
    state_t                         state_reg, state_next;
    logic [pesf_pkg::FLAGS_W-1:0]   health_reg, health_next;
    logic [pesf_pkg::ID_W-1:0]      planned_reg, planned_next;
    logic [pesf_pkg::ID_W-1:0]      session_reg, session_next;
    logic                           pause_pend_reg, pause_pend_next;
    logic [pesf_pkg::ERR_W-1:0]     err_reg, err_next;

    // result register
    logic                           out_valid_reg;
    logic [pesf_pkg::REJ_W-1:0]     rej_reg, rej_next;
    logic [pesf_pkg::STATE_W-1:0]   ostate_reg;
    logic [pesf_pkg::PERM_W-1:0]    operm_reg;
    logic [pesf_pkg::ID_W-1:0]      oplanned_reg;
    logic [pesf_pkg::ID_W-1:0]      osession_reg;
    logic [pesf_pkg::ERR_W-1:0]     oerr_reg;
    logic                           oready_reg;

    logic                           advance;
    logic                           rdy_now;
    logic                           new_ok;
    logic                           tag_match;
    logic [pesf_pkg::PERM_W-1:0]    perm_now;

    assign advance  = ir_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !ir_valid_reg || advance;

    assign rdy_now   = (health_reg == pesf_pkg::FLAGS_ALL_OK);
    assign new_ok    = (ir_flags_reg == pesf_pkg::FLAGS_ALL_OK);
    assign tag_match = (ir_tag_reg == session_reg);
    assign perm_now  = pesf_pkg::perm_of(state_reg);

    always_comb
    begin
        state_next      = state_reg;
        health_next     = health_reg;
        planned_next    = planned_reg;
        session_next    = session_reg;
        pause_pend_next = pause_pend_reg;
        err_next        = err_reg;
        rej_next        = pesf_pkg::REJ_NONE;

        case (ir_op_reg)
            pesf_pkg::OP_READINESS:
            begin
                health_next = ir_flags_reg;
                case (state_reg)
                    ST_NOTREADY:
                    begin
                        if (new_ok)
                            state_next = ST_READY;
                    end
                    ST_READY, ST_SUCCEEDED:
                    begin
                        if (!new_ok)
                            state_next = ST_NOTREADY;
                    end
                    ST_PLANNING, ST_EXECUTING, ST_PAUSED:
                    begin
                        if (!new_ok)
                        begin
                            planned_next    = '0;
                            pause_pend_next = 1'b0;
                            err_next        = pesf_pkg::ERR_READINESS_LOST;
                            state_next      = ST_ERROR;
                        end
                    end
                    ST_PLANNED:
                    begin
                        if (!new_ok)
                        begin
                            planned_next = '0;
                            state_next   = ST_NOTREADY;
                        end
                    end
                    default: ;
                endcase
            end
            pesf_pkg::OP_PLAN:
            begin
                if (!perm_now[pesf_pkg::P_PLAN])
                    rej_next = pesf_pkg::REJ_PLAN_DENIED;
                else if (!rdy_now)
                    rej_next = pesf_pkg::REJ_NOT_READY;
                else
                begin
                    planned_next    = '0;
                    pause_pend_next = 1'b0;
                    err_next        = pesf_pkg::ERR_NONE;
                    session_next    = session_reg + pesf_pkg::ID_W'(1);
                    state_next      = ST_PLANNING;
                end
            end
            pesf_pkg::OP_EXECUTE:
            begin
                if (!perm_now[pesf_pkg::P_EXEC])
                    rej_next = pesf_pkg::REJ_EXEC_DENIED;
                else if (!rdy_now)
                    rej_next = pesf_pkg::REJ_NOT_READY;
                else if (state_reg != ST_PLANNED || ir_cand_reg == '0
                         || ir_cand_reg != planned_reg)
                    rej_next = pesf_pkg::REJ_STALE;
                else
                begin
                    pause_pend_next = 1'b0;
                    state_next      = ST_EXECUTING;
                end
            end
            pesf_pkg::OP_PAUSE:
            begin
                if (!perm_now[pesf_pkg::P_PAUSE])
                    rej_next = pesf_pkg::REJ_PAUSE_DENIED;
                else
                    pause_pend_next = 1'b1;
            end
            pesf_pkg::OP_RESUME:
            begin
                if (!perm_now[pesf_pkg::P_RESUME])
                    rej_next = pesf_pkg::REJ_RESUME_DENIED;
                else if (!ir_tol_reg)
                    rej_next = pesf_pkg::REJ_TOLERANCE;
                else if (!rdy_now)
                    rej_next = pesf_pkg::REJ_NOT_READY;
                else
                begin
                    pause_pend_next = 1'b0;
                    state_next      = ST_EXECUTING;
                end
            end
            pesf_pkg::OP_ABORT:
            begin
                if (!perm_now[pesf_pkg::P_ABORT])
                    rej_next = pesf_pkg::REJ_ABORT_DENIED;
                else if (state_reg == ST_ERROR && !rdy_now)
                    rej_next = pesf_pkg::REJ_NOT_READY;
                else
                begin
                    planned_next    = '0;
                    pause_pend_next = 1'b0;
                    err_next        = pesf_pkg::ERR_NONE;
                    // aborting a plan retires its session
                    if (state_reg == ST_PLANNING)
                        session_next = session_reg + pesf_pkg::ID_W'(1);
                    state_next = ST_READY;
                end
            end
            pesf_pkg::OP_VALIDATED:
            begin
                if (state_reg == ST_PLANNING && tag_match)
                begin
                    if (!ir_cvalid_reg || ir_cand_reg == '0)
                    begin
                        planned_next = '0;
                        state_next   = ST_READY;
                    end
                    else
                    begin
                        planned_next = ir_cand_reg;
                        state_next   = ST_PLANNED;
                    end
                end
            end
            pesf_pkg::OP_PLAN_FAIL:
            begin
                if (state_reg == ST_PLANNING && tag_match)
                begin
                    planned_next = '0;
                    err_next     = ir_code_reg;
                    state_next   = ir_corrupt_reg ? ST_ERROR : ST_READY;
                end
            end
            pesf_pkg::OP_PAUSE_OK:
            begin
                if (state_reg == ST_EXECUTING && pause_pend_reg)
                begin
                    pause_pend_next = 1'b0;
                    state_next      = ST_PAUSED;
                end
            end
            pesf_pkg::OP_SUCCESS:
            begin
                if (state_reg == ST_EXECUTING)
                begin
                    pause_pend_next = 1'b0;
                    state_next      = ST_SUCCEEDED;
                end
            end
            pesf_pkg::OP_FAULT:
            begin
                if (state_reg == ST_EXECUTING || state_reg == ST_PAUSED)
                begin
                    planned_next    = '0;
                    pause_pend_next = 1'b0;
                    err_next        = ir_code_reg;
                    state_next      = ST_ERROR;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= ST_NOTREADY;
            health_reg     <= '0;
            planned_reg    <= '0;
            session_reg    <= '0;
            pause_pend_reg <= 1'b0;
            err_reg        <= pesf_pkg::ERR_NONE;
            rej_reg        <= pesf_pkg::REJ_NONE;
            ostate_reg     <= ST_NOTREADY;
            operm_reg      <= '0;
            oplanned_reg   <= '0;
            osession_reg   <= '0;
            oerr_reg       <= pesf_pkg::ERR_NONE;
            oready_reg     <= 1'b0;
        end
        else
        begin
            if (in_ready)
                ir_valid_reg <= in_valid;

            if (advance)
            begin
                state_reg      <= state_next;
                health_reg     <= health_next;
                planned_reg    <= planned_next;
                session_reg    <= session_next;
                pause_pend_reg <= pause_pend_next;
                err_reg        <= err_next;
                out_valid_reg  <= 1'b1;
                rej_reg        <= rej_next;
                ostate_reg     <= state_next;
                operm_reg      <= pesf_pkg::perm_of(state_next);
                oplanned_reg   <= planned_next;
                osession_reg   <= session_next;
                oerr_reg       <= err_next;
                oready_reg     <= (health_next == pesf_pkg::FLAGS_ALL_OK);
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // input payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ir_op_reg      <= op;
            ir_flags_reg   <= ready_flags;
            ir_cand_reg    <= cand_id;
            ir_tag_reg     <= session_tag;
            ir_code_reg    <= fault_code;
            ir_tol_reg     <= tol_ok;
            ir_cvalid_reg  <= candidate_valid;
            ir_corrupt_reg <= protocol_corrupt;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = (rej_reg == pesf_pkg::REJ_NONE);
    assign reject_code    = rej_reg;
    assign cur_state      = ostate_reg;
    assign allowed_cmds   = operm_reg;
    assign planned_id     = oplanned_reg;
    assign session_num    = osession_reg;
    assign error_code_out = oerr_reg;
    assign is_ready       = oready_reg;

    // only Executing can have a pause outstanding
    a_pause_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        pause_pend_reg |-> state_reg == ST_EXECUTING)
        else $error("pause pending outside Executing");

    // every state other than NotReady and Error implies full health
    a_health: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_NOTREADY && state_reg != ST_ERROR) |-> rdy_now)
        else $error("active state with health flags not all set");

    // NotReady never holds with full health
    a_notready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NOTREADY |-> !rdy_now)
        else $error("NotReady while health flags all set");

    // session counter moves by at most one per cycle
    a_session_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (session_reg == $past(session_reg)
             || session_reg == $past(session_reg) + pesf_pkg::ID_W'(1)))
        else $error("session counter jumped");

    // reported permissions match reported state
    a_perm_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> operm_reg == pesf_pkg::perm_of(ostate_reg))
        else $error("allowed_cmds does not match cur_state");

endmodule

`default_nettype wire

### sim/plan_execute_supervisor_fsm_core_tb.sv
module plan_execute_supervisor_fsm_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_PER_PHASE = 150;
    localparam int NUM_PHASES     = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // highest op code; everything above OP_FAULT is ignored by the block
    localparam logic [pesf_pkg::OP_W-1:0] OP_UNUSED_MAX = 4'hF;

    typedef enum logic [pesf_pkg::STATE_W-1:0] {
        S_NOT_READY,
        S_READY,
        S_PLANNING,
        S_PLANNED,
        S_EXECUTING,
        S_PAUSED,
        S_SUCCEEDED,
        S_ERROR
    } sv_state_t;

    typedef struct {
        logic [pesf_pkg::OP_W-1:0]    op;
        logic [pesf_pkg::FLAGS_W-1:0] flags;
        logic [pesf_pkg::ID_W-1:0]    cand;
        logic [pesf_pkg::ID_W-1:0]    tag;
        logic [pesf_pkg::ERR_W-1:0]   code;
        logic                         tol;
        logic                         valid;
        logic                         corrupt;
    } cmd_item_t;

    typedef struct {
        logic                         acc;
        logic [pesf_pkg::REJ_W-1:0]   rej;
        logic [pesf_pkg::STATE_W-1:0] st;
        logic [pesf_pkg::PERM_W-1:0]  perms;
        logic [pesf_pkg::ID_W-1:0]    planned;
        logic [pesf_pkg::ID_W-1:0]    session;
        logic [pesf_pkg::ERR_W-1:0]   err;
        logic                         rdy;
    } status_t;

    typedef struct {
        cmd_item_t                    item;
        bit                           typed;
        logic                         acc;
        logic [pesf_pkg::REJ_W-1:0]   rej;
        sv_state_t                    st;
    } dir_row_t;

    logic                          clk              = 1'b0;
    logic                          rst_n            = 1'b0;
    logic                          in_valid         = 1'b0;
    logic                          in_ready;
    logic [pesf_pkg::OP_W-1:0]     op               = pesf_pkg::OP_READINESS;
    logic [pesf_pkg::FLAGS_W-1:0]  ready_flags      = '0;
    logic [pesf_pkg::ID_W-1:0]     cand_id          = '0;
    logic [pesf_pkg::ID_W-1:0]     session_tag      = '0;
    logic [pesf_pkg::ERR_W-1:0]    fault_code       = '0;
    logic                          tol_ok           = 1'b0;
    logic                          candidate_valid  = 1'b0;
    logic                          protocol_corrupt = 1'b0;
    logic                          out_valid;
    logic                          out_ready        = 1'b0;
    logic                          accepted;
    logic [pesf_pkg::REJ_W-1:0]    reject_code;
    logic [pesf_pkg::STATE_W-1:0]  cur_state;
    logic [pesf_pkg::PERM_W-1:0]   allowed_cmds;
    logic [pesf_pkg::ID_W-1:0]     planned_id;
    logic [pesf_pkg::ID_W-1:0]     session_num;
    logic [pesf_pkg::ERR_W-1:0]    error_code_out;
    logic                          is_ready;

    // supervisor shadow state
    sv_state_t                     sv_state      = S_NOT_READY;
    logic [pesf_pkg::FLAGS_W-1:0]  sv_flags      = '0;
    logic [pesf_pkg::ID_W-1:0]     sv_planned    = '0;
    logic [pesf_pkg::ID_W-1:0]     sv_session    = '0;
    logic                          sv_pause_pend = 1'b0;
    logic [pesf_pkg::ERR_W-1:0]    sv_err        = pesf_pkg::ERR_NONE;

    status_t             status_due[$];
    dir_row_t            dir_rows[$];

    int                  send_idle_pct = 0;
    int                  stall_pct     = 0;
    int                  fail_count    = 0;
    int                  items_sent    = 0;
    int                  results_seen  = 0;
    int                  idle_cycles   = 0;
    logic [15:0]         ops_seen      = '0;
    logic [7:0]          states_seen   = '0;
    int                  rejects_seen  = 0;

    plan_execute_supervisor_fsm_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .ready_flags      (ready_flags),
        .cand_id          (cand_id),
        .session_tag      (session_tag),
        .fault_code       (fault_code),
        .tol_ok           (tol_ok),
        .candidate_valid  (candidate_valid),
        .protocol_corrupt (protocol_corrupt),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .accepted         (accepted),
        .reject_code      (reject_code),
        .cur_state        (cur_state),
        .allowed_cmds     (allowed_cmds),
        .planned_id       (planned_id),
        .session_num      (session_num),
        .error_code_out   (error_code_out),
        .is_ready         (is_ready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [pesf_pkg::PERM_W-1:0] cmds_permitted(input sv_state_t s);
        logic [pesf_pkg::PERM_W-1:0] m;
        m = '0;
        case (s)
            S_READY, S_SUCCEEDED:
                m[pesf_pkg::P_PLAN] = 1'b1;
            S_PLANNING, S_ERROR:
                m[pesf_pkg::P_ABORT] = 1'b1;
            S_PLANNED:
            begin
                m[pesf_pkg::P_PLAN]  = 1'b1;
                m[pesf_pkg::P_EXEC]  = 1'b1;
                m[pesf_pkg::P_ABORT] = 1'b1;
            end
            S_EXECUTING:
            begin
                m[pesf_pkg::P_PAUSE] = 1'b1;
                m[pesf_pkg::P_ABORT] = 1'b1;
            end
            S_PAUSED:
            begin
                m[pesf_pkg::P_RESUME] = 1'b1;
                m[pesf_pkg::P_ABORT]  = 1'b1;
            end
            default:
                m = '0;
        endcase
        return m;
    endfunction

    // advances the shadow supervisor by one item and returns its status report
    function automatic status_t step_supervisor(input cmd_item_t it);
        status_t                     r;
        logic [pesf_pkg::REJ_W-1:0]  rej;
        logic [pesf_pkg::PERM_W-1:0] pm;
        logic                        rdy;
        rej = pesf_pkg::REJ_NONE;
        pm  = cmds_permitted(sv_state);
        rdy = (sv_flags == pesf_pkg::FLAGS_ALL_OK);
        case (it.op)
            pesf_pkg::OP_READINESS:
            begin
                sv_flags = it.flags;
                rdy      = (it.flags == pesf_pkg::FLAGS_ALL_OK);
                case (sv_state)
                    S_NOT_READY:
                        if (rdy)
                            sv_state = S_READY;
                    S_READY, S_SUCCEEDED:
                        if (!rdy)
                            sv_state = S_NOT_READY;
                    S_PLANNING, S_EXECUTING, S_PAUSED:
                        if (!rdy)
                        begin
                            sv_planned    = '0;
                            sv_pause_pend = 1'b0;
                            sv_err        = pesf_pkg::ERR_READINESS_LOST;
                            sv_state      = S_ERROR;
                        end
                    S_PLANNED:
                        if (!rdy)
                        begin
                            sv_planned = '0;
                            sv_state   = S_NOT_READY;
                        end
                    default:
                        ;
                endcase
            end
            pesf_pkg::OP_PLAN:
                if (!pm[pesf_pkg::P_PLAN])
                    rej = pesf_pkg::REJ_PLAN_DENIED;
                else if (!rdy)
                    rej = pesf_pkg::REJ_NOT_READY;
                else
                begin
                    sv_planned    = '0;
                    sv_pause_pend = 1'b0;
                    sv_err        = pesf_pkg::ERR_NONE;
                    sv_session    = sv_session + 1'b1;
                    sv_state      = S_PLANNING;
                end
            pesf_pkg::OP_EXECUTE:
                if (!pm[pesf_pkg::P_EXEC])
                    rej = pesf_pkg::REJ_EXEC_DENIED;
                else if (!rdy)
                    rej = pesf_pkg::REJ_NOT_READY;
                else if (sv_state != S_PLANNED || it.cand == '0 || it.cand != sv_planned)
                    rej = pesf_pkg::REJ_STALE;
                else
                begin
                    sv_pause_pend = 1'b0;
                    sv_state      = S_EXECUTING;
                end
            pesf_pkg::OP_PAUSE:
                if (!pm[pesf_pkg::P_PAUSE])
                    rej = pesf_pkg::REJ_PAUSE_DENIED;
                else
                    sv_pause_pend = 1'b1;
            pesf_pkg::OP_RESUME:
                if (!pm[pesf_pkg::P_RESUME])
                    rej = pesf_pkg::REJ_RESUME_DENIED;
                else if (!it.tol)
                    rej = pesf_pkg::REJ_TOLERANCE;
                else if (!rdy)
                    rej = pesf_pkg::REJ_NOT_READY;
                else
                begin
                    sv_pause_pend = 1'b0;
                    sv_state      = S_EXECUTING;
                end
            pesf_pkg::OP_ABORT:
                if (!pm[pesf_pkg::P_ABORT])
                    rej = pesf_pkg::REJ_ABORT_DENIED;
                else if (sv_state == S_ERROR && !rdy)
                    rej = pesf_pkg::REJ_NOT_READY;
                else
                begin
                    sv_planned    = '0;
                    sv_pause_pend = 1'b0;
                    sv_err        = pesf_pkg::ERR_NONE;
                    if (sv_state == S_PLANNING)
                        sv_session = sv_session + 1'b1;
                    sv_state = S_READY;
                end
            pesf_pkg::OP_VALIDATED:
                if (sv_state == S_PLANNING && it.tag == sv_session)
                begin
                    if (!it.valid || it.cand == '0)
                    begin
                        sv_planned = '0;
                        sv_state   = S_READY;
                    end
                    else
                    begin
                        sv_planned = it.cand;
                        sv_state   = S_PLANNED;
                    end
                end
            pesf_pkg::OP_PLAN_FAIL:
                if (sv_state == S_PLANNING && it.tag == sv_session)
                begin
                    sv_planned = '0;
                    sv_err     = it.code;
                    sv_state   = it.corrupt ? S_ERROR : S_READY;
                end
            pesf_pkg::OP_PAUSE_OK:
                if (sv_state == S_EXECUTING && sv_pause_pend)
                begin
                    sv_pause_pend = 1'b0;
                    sv_state      = S_PAUSED;
                end
            pesf_pkg::OP_SUCCESS:
                if (sv_state == S_EXECUTING)
                begin
                    sv_pause_pend = 1'b0;
                    sv_state      = S_SUCCEEDED;
                end
            pesf_pkg::OP_FAULT:
                if (sv_state == S_EXECUTING || sv_state == S_PAUSED)
                begin
                    sv_planned    = '0;
                    sv_pause_pend = 1'b0;
                    sv_err        = it.code;
                    sv_state      = S_ERROR;
                end
            default:
                ;
        endcase
        r.acc     = (rej == pesf_pkg::REJ_NONE);
        r.rej     = rej;
        r.st      = sv_state;
        r.perms   = cmds_permitted(sv_state);
        r.planned = sv_planned;
        r.session = sv_session;
        r.err     = sv_err;
        r.rdy     = (sv_flags == pesf_pkg::FLAGS_ALL_OK);
        return r;
    endfunction

    function automatic cmd_item_t mk_item(input logic [pesf_pkg::OP_W-1:0] o,
                                          input logic [pesf_pkg::FLAGS_W-1:0] f,
                                          input logic [pesf_pkg::ID_W-1:0] c,
                                          input logic [pesf_pkg::ID_W-1:0] t,
                                          input logic [pesf_pkg::ERR_W-1:0] e,
                                          input logic tl, input logic vl, input logic cr);
        cmd_item_t it;
        it.op      = o;
        it.flags   = f;
        it.cand    = c;
        it.tag     = t;
        it.code    = e;
        it.tol     = tl;
        it.valid   = vl;
        it.corrupt = cr;
        return it;
    endfunction

    task automatic add_row(input cmd_item_t it);
        dir_row_t row;
        row.item  = it;
        row.typed = 1'b0;
        row.acc   = 1'b1;
        row.rej   = pesf_pkg::REJ_NONE;
        row.st    = S_NOT_READY;
        dir_rows.push_back(row);
    endtask

    task automatic add_checked(input cmd_item_t it, input logic a,
                               input logic [pesf_pkg::REJ_W-1:0] rj, input sv_state_t s);
        dir_row_t row;
        row.item  = it;
        row.typed = 1'b1;
        row.acc   = a;
        row.rej   = rj;
        row.st    = s;
        dir_rows.push_back(row);
    endtask

    function automatic logic [pesf_pkg::FLAGS_W-1:0] flags_with_loss();
        return pesf_pkg::FLAGS_W'($urandom_range(255) & ~(32'h1 << $urandom_range(7)));
    endfunction

    // mostly a sensible next item for the current state, the rest pure noise
    function automatic cmd_item_t pick_item();
        cmd_item_t it;
        int        r;
        it.op      = pesf_pkg::OP_W'($urandom_range(15));
        it.flags   = pesf_pkg::FLAGS_W'($urandom_range(255));
        it.cand    = {$urandom, $urandom};
        it.tag     = {$urandom, $urandom};
        it.code    = pesf_pkg::ERR_W'($urandom_range(255));
        it.tol     = ($urandom_range(1) != 0);
        it.valid   = ($urandom_range(1) != 0);
        it.corrupt = ($urandom_range(1) != 0);
        if ($urandom_range(99) < 75)
        begin
            it.tag  = sv_session;
            it.code = pesf_pkg::ERR_W'($urandom_range(255, 2));
            case (sv_state)
                S_NOT_READY:
                begin
                    it.op    = pesf_pkg::OP_READINESS;
                    it.flags = ($urandom_range(9) < 8) ? pesf_pkg::FLAGS_ALL_OK
                                                       : flags_with_loss();
                end
                S_READY:
                begin
                    r = $urandom_range(9);
                    it.op = (r < 7) ? pesf_pkg::OP_PLAN : pesf_pkg::OP_READINESS;
                    it.flags = (r == 7) ? pesf_pkg::FLAGS_ALL_OK : flags_with_loss();
                end
                S_PLANNING:
                begin
                    r = $urandom_range(19);
                    if (r < 9)
                    begin
                        it.op    = pesf_pkg::OP_VALIDATED;
                        it.valid = ($urandom_range(4) != 0);
                        if ($urandom_range(7) == 0)
                            it.cand = '0;
                    end
                    else if (r < 14)
                        it.op = pesf_pkg::OP_PLAN_FAIL;
                    else if (r < 16)
                        it.op = pesf_pkg::OP_ABORT;
                    else if (r == 16)
                    begin
                        it.op    = pesf_pkg::OP_READINESS;
                        it.flags = flags_with_loss();
                    end
                    else
                        it.tag = sv_session + 1'b1;
                end
                S_PLANNED:
                begin
                    r = $urandom_range(19);
                    if (r < 10)
                    begin
                        it.op   = pesf_pkg::OP_EXECUTE;
                        it.cand = sv_planned;
                    end
                    else if (r < 12)
                        it.op = pesf_pkg::OP_EXECUTE;
                    else if (r < 14)
                        it.op = pesf_pkg::OP_PLAN;
                    else if (r < 16)
                        it.op = pesf_pkg::OP_ABORT;
                    else
                    begin
                        it.op    = pesf_pkg::OP_READINESS;
                        it.flags = (r == 16) ? flags_with_loss() : pesf_pkg::FLAGS_ALL_OK;
                    end
                end
                S_EXECUTING:
                begin
                    r = $urandom_range(19);
                    if (r < 5)
                        it.op = pesf_pkg::OP_PAUSE;
                    else if (r < 9 || r > 15)
                        it.op = pesf_pkg::OP_PAUSE_OK;
                    else if (r < 12)
                        it.op = pesf_pkg::OP_SUCCESS;
                    else if (r < 14)
                        it.op = pesf_pkg::OP_FAULT;
                    else if (r == 14)
                        it.op = pesf_pkg::OP_ABORT;
                    else
                    begin
                        it.op    = pesf_pkg::OP_READINESS;
                        it.flags = flags_with_loss();
                    end
                end
                S_PAUSED:
                begin
                    r = $urandom_range(19);
                    if (r < 10 || r > 14)
                    begin
                        it.op  = pesf_pkg::OP_RESUME;
                        it.tol = ($urandom_range(3) != 0);
                    end
                    else if (r < 12)
                        it.op = pesf_pkg::OP_FAULT;
                    else if (r < 14)
                        it.op = pesf_pkg::OP_ABORT;
                    else
                    begin
                        it.op    = pesf_pkg::OP_READINESS;
                        it.flags = flags_with_loss();
                    end
                end
                S_SUCCEEDED:
                begin
                    r = $urandom_range(9);
                    if (r < 7)
                        it.op = pesf_pkg::OP_PLAN;
                    else if (r < 9)
                    begin
                        it.op    = pesf_pkg::OP_READINESS;
                        it.flags = flags_with_loss();
                    end
                    else
                        it.op = pesf_pkg::OP_SUCCESS;
                end
                default:
                begin
                    r = $urandom_range(9);
                    if (r < 6)
                        it.op = pesf_pkg::OP_ABORT;
                    else
                    begin
                        it.op    = pesf_pkg::OP_READINESS;
                        it.flags = (r < 8) ? pesf_pkg::FLAGS_ALL_OK : flags_with_loss();
                    end
                end
            endcase
        end
        return it;
    endfunction

    // presents one beat and returns at the edge where it is taken
    task automatic drive_item(input cmd_item_t it, input bit typed, input logic a,
                              input logic [pesf_pkg::REJ_W-1:0] rj, input sv_state_t s);
        status_t st;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        op               <= it.op;
        ready_flags      <= it.flags;
        cand_id          <= it.cand;
        session_tag      <= it.tag;
        fault_code       <= it.code;
        tol_ok           <= it.tol;
        candidate_valid  <= it.valid;
        protocol_corrupt <= it.corrupt;
        do
            @(posedge clk);
        while (!in_ready);
        st = step_supervisor(it);
        if (typed)
        begin
            st.acc = a;
            st.rej = rj;
            st.st  = s;
        end
        status_due.push_back(st);
        items_sent++;
        ops_seen[it.op] = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_side
        status_t exp_s;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (status_due.size() == 0)
                begin
                    $error("result beat with no status expected");
                    fail_count++;
                end
                else
                begin
                    exp_s = status_due.pop_front();
                    states_seen[exp_s.st] = 1'b1;
                    if (!exp_s.acc)
                        rejects_seen++;
                    check_field("accepted", 64'(exp_s.acc), 64'(accepted));
                    check_field("reject_code", 64'(exp_s.rej), 64'(reject_code));
                    check_field("cur_state", 64'(exp_s.st), 64'(cur_state));
                    check_field("allowed_cmds", 64'(exp_s.perms), 64'(allowed_cmds));
                    check_field("planned_id", exp_s.planned, planned_id);
                    check_field("session_num", exp_s.session, session_num);
                    check_field("error_code_out", 64'(exp_s.err), 64'(error_code_out));
                    check_field("is_ready", 64'(exp_s.rdy), 64'(is_ready));
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         idle_cycles, status_due.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        add_checked(mk_item(pesf_pkg::OP_PLAN, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0), 1'b0,
                    pesf_pkg::REJ_PLAN_DENIED, S_NOT_READY);
        add_checked(mk_item(OP_UNUSED_MAX, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1), 1'b1,
                    pesf_pkg::REJ_NONE, S_NOT_READY);
        add_checked(mk_item(pesf_pkg::OP_EXECUTE, '0, '1, '0, '0, 1'b0, 1'b0, 1'b0), 1'b0,
                    pesf_pkg::REJ_EXEC_DENIED, S_NOT_READY);
        add_checked(mk_item(pesf_pkg::OP_PAUSE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0), 1'b0,
                    pesf_pkg::REJ_PAUSE_DENIED, S_NOT_READY);
        add_checked(mk_item(pesf_pkg::OP_RESUME, '0, '0, '0, '0, 1'b1, 1'b0, 1'b0), 1'b0,
                    pesf_pkg::REJ_RESUME_DENIED, S_NOT_READY);
        add_checked(mk_item(pesf_pkg::OP_ABORT, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0), 1'b0,
                    pesf_pkg::REJ_ABORT_DENIED, S_NOT_READY);
        add_checked(mk_item(pesf_pkg::OP_READINESS, 8'h7F, '0, '0, '0, 1'b0, 1'b0, 1'b0),
                    1'b1, pesf_pkg::REJ_NONE, S_NOT_READY);
        add_checked(mk_item(pesf_pkg::OP_READINESS, pesf_pkg::FLAGS_ALL_OK, '0, '0, '0,
                            1'b0, 1'b0, 1'b0),
                    1'b1, pesf_pkg::REJ_NONE, S_READY);
        add_row(mk_item(pesf_pkg::OP_PLAN, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        // tag from an older session must be ignored
        add_row(mk_item(pesf_pkg::OP_VALIDATED, '0, 64'd5, 64'd0, '0, 1'b0, 1'b1, 1'b0));
        add_row(mk_item(pesf_pkg::OP_VALIDATED, '0, '1, 64'd1, '0, 1'b0, 1'b1, 1'b0));
        add_checked(mk_item(pesf_pkg::OP_EXECUTE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0), 1'b0,
                    pesf_pkg::REJ_STALE, S_PLANNED);
        add_row(mk_item(pesf_pkg::OP_EXECUTE, '0, '1, '0, '0, 1'b0, 1'b0, 1'b0));
        add_row(mk_item(pesf_pkg::OP_PAUSE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        add_row(mk_item(pesf_pkg::OP_PAUSE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        add_row(mk_item(pesf_pkg::OP_PAUSE_OK, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        add_checked(mk_item(pesf_pkg::OP_RESUME, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0), 1'b0,
                    pesf_pkg::REJ_TOLERANCE, S_PAUSED);
        add_row(mk_item(pesf_pkg::OP_RESUME, '0, '0, '0, '0, 1'b1, 1'b0, 1'b0));
        // fault code that aliases "no error"
        add_row(mk_item(pesf_pkg::OP_FAULT, '0, '0, '0, 8'd0, 1'b0, 1'b0, 1'b0));
        add_row(mk_item(pesf_pkg::OP_READINESS, 8'h00, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        add_checked(mk_item(pesf_pkg::OP_ABORT, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0), 1'b0,
                    pesf_pkg::REJ_NOT_READY, S_ERROR);
        add_row(mk_item(pesf_pkg::OP_READINESS, pesf_pkg::FLAGS_ALL_OK, '0, '0, '0,
                        1'b0, 1'b0, 1'b0));
        add_row(mk_item(pesf_pkg::OP_ABORT, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        add_row(mk_item(pesf_pkg::OP_PLAN, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        // abort out of Planning bumps the session too
        add_row(mk_item(pesf_pkg::OP_ABORT, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        add_row(mk_item(pesf_pkg::OP_PLAN, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        add_row(mk_item(pesf_pkg::OP_READINESS, 8'hFE, '0, '0, '0, 1'b0, 1'b0, 1'b0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].acc, dir_rows[i].rej,
                       dir_rows[i].st);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 80;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 80;
                end
                default:
                begin
                    send_idle_pct = 18;
                    stall_pct     = 18;
                end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++)
                drive_item(pick_item(), 1'b0, 1'b1, pesf_pkg::REJ_NONE, S_NOT_READY);
        end
        in_valid <= 1'b0;

        while (status_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (status_due.size() != 0)
        begin
            $error("%0d expected status beats never arrived", status_due.size());
            fail_count++;
        end

        $display("%0d items driven (%0d from the directed table), %0d status beats compared",
                 items_sent, dir_rows.size(), results_seen);
        $display("ops exercised 0x%04h, states reached 0x%02h, %0d rejected commands, %0d errors",
                 ops_seen, states_seen, rejects_seen, fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
design/pesf_pkg.sv
design/plan_execute_supervisor_fsm_core.sv
sim/plan_execute_supervisor_fsm_core_tb.sv
